### rtl/assert_macros.svh
// Shared assertion macros for the block checkers.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, off while in reset.
`define ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// Next-cycle implication, off while in reset.
`define ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`endif

### rtl/sefc_pkg.sv
`default_nettype none
package sefc_pkg;

    localparam int LEN_BITS   = 12;
    localparam int DIR_BITS   = 16;
    localparam int SIZE_BITS  = 13;
    localparam int SUM_BITS   = 32;
    localparam int SQRT_STEPS = 16;
    localparam int ROOT_BITS  = 17;
    localparam int DEN_BITS   = ROOT_BITS + 1;
    localparam int QUO_BITS   = 11;
    localparam int NUM_BITS   = DIR_BITS + LEN_BITS;
    localparam int ADDR_BITS  = 3;

    localparam logic signed [DIR_BITS-1:0] SMALL_DIR = 16'sd163;
    localparam logic signed [DIR_BITS-1:0] UNIT_Q14  = 16'sd16384;

    localparam logic [SIZE_BITS-1:0] WIDTH_RESET  = 13'd640;
    localparam logic [SIZE_BITS-1:0] HEIGHT_RESET = 13'd480;

    typedef enum logic [ADDR_BITS-1:0] {
        REG_IMAGE_WIDTH  = 3'd0,
        REG_IMAGE_HEIGHT = 3'd4
    } reg_addr_t;

endpackage
`default_nettype wire

### rtl/sefc_in_if.sv
`default_nettype none
interface sefc_in_if #(parameter int CW = 12);
    logic                                 valid;
    logic                                 ready;
    logic [CW-1:0]                        center_x;
    logic [CW-1:0]                        center_y;
    logic [sefc_pkg::LEN_BITS-1:0]        seg_length;
    logic signed [sefc_pkg::DIR_BITS-1:0] dir_x;
    logic signed [sefc_pkg::DIR_BITS-1:0] dir_y;

    modport source (output valid, center_x, center_y, seg_length, dir_x, dir_y, input ready);
    modport sink   (input valid, center_x, center_y, seg_length, dir_x, dir_y, output ready);
endinterface
`default_nettype wire

### rtl/sefc_out_if.sv
`default_nettype none
interface sefc_out_if #(parameter int CW = 12);
    logic          valid;
    logic          ready;
    logic [CW-1:0] end_a_x;
    logic [CW-1:0] end_a_y;
    logic [CW-1:0] end_b_x;
    logic [CW-1:0] end_b_y;

    modport source (output valid, end_a_x, end_a_y, end_b_x, end_b_y, input ready);
    modport sink   (input valid, end_a_x, end_a_y, end_b_x, end_b_y, output ready);
endinterface
`default_nettype wire

### rtl/segment_endpoints_from_center.sv
// Segment endpoints from centre, length and direction.
// seg_in carries one item per segment: centre, full length and a Q2.14
// direction. seg_out returns one item per input: both endpoints, centre
// plus and minus the direction scaled to half the length, clamped to the
// image set through the APB registers (width at 0x0, height at 0x4).
// A direction with both components within 163 of zero is taken as (1,1).
// From input acceptance to output valid there is one stage
// for direction fix-up, one for the squares, one for their sum, sixteen
// square-root stages, one multiply stage and eleven divide stages, then
// the clamping output register. Throughput is one item per cycle unless the
// receiver stalls; the pipelined root and the two pipelined dividers set it.
// The whole pipeline advances together; when the receiver stalls with a
// result waiting, every stage holds and seg_in.ready drops, so nothing is
// lost or repeated. Bubbles are not squeezed out during a stall.
// Reset clears every valid bit and loads width 640, height 480.
// Write the registers only while the pipeline is empty.
`default_nettype none
module segment_endpoints_from_center #(
    parameter int COORD_BITS = 12
) (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    sefc_in_if.sink                                    seg_in,
    sefc_out_if.source                                 seg_out,
    input  wire logic                                  psel,
    input  wire logic                                  penable,
    input  wire logic                                  pwrite,
    input  wire logic [sefc_pkg::ADDR_BITS-1:0]        paddr,
    input  wire logic [31:0]                           pwdata,
    output logic      [31:0]                           prdata,
    output logic                                       pready
);

    localparam int CW  = COORD_BITS;
    localparam int NS  = sefc_pkg::SQRT_STEPS;
    localparam int NQ  = sefc_pkg::QUO_BITS;
    localparam int LB  = sefc_pkg::LEN_BITS;
    localparam int DB  = sefc_pkg::DIR_BITS;
    localparam int SB  = sefc_pkg::SUM_BITS;
    localparam int NB  = sefc_pkg::NUM_BITS;
    localparam int RB  = sefc_pkg::ROOT_BITS;
    localparam int EB  = sefc_pkg::DEN_BITS;
    localparam int ZB  = sefc_pkg::SIZE_BITS;
    localparam int VW  = ((CW + 2 > ZB + 1) ? CW + 2 : ZB + 1) + 1;
    localparam logic signed [VW-1:0] CMAX = VW'((1 << CW) - 1);

    // ---------------- configuration registers ----------------
    logic [ZB-1:0] width_reg;
    logic [ZB-1:0] height_reg;
    logic          cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= sefc_pkg::WIDTH_RESET;
            height_reg <= sefc_pkg::HEIGHT_RESET;
        end
        else if (cfg_wr)
        begin
            unique case (paddr)
                sefc_pkg::REG_IMAGE_WIDTH:  width_reg  <= pwdata[ZB-1:0];
                sefc_pkg::REG_IMAGE_HEIGHT: height_reg <= pwdata[ZB-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr)
            sefc_pkg::REG_IMAGE_WIDTH:  prdata = 32'(width_reg);
            sefc_pkg::REG_IMAGE_HEIGHT: prdata = 32'(height_reg);
            default:                    prdata = '0;
        endcase
    end

    // Upper clamp bound: size minus one, held to the coordinate range.
    function automatic logic signed [VW-1:0] upper_bound(input logic [ZB-1:0] size);
        logic signed [VW-1:0] hi;
        hi = $signed(VW'(size)) - VW'(1);
        if (hi > CMAX)
            hi = CMAX;
        return hi;
    endfunction

    function automatic logic [CW-1:0] clamp(input logic signed [VW-1:0] v,
                                            input logic signed [VW-1:0] hi);
        logic signed [VW-1:0] r;
        r = v;
        if (r > hi)
            r = hi;
        if (r < 0)
            r = '0;
        return r[CW-1:0];
    endfunction

    // ---------------- pipeline control ----------------
    logic out_valid_reg;
    logic adv;

    assign adv          = !out_valid_reg || seg_out.ready;
    assign seg_in.ready = adv;

    // ---------------- stage A: direction fix-up ----------------
    logic                 a_valid_reg;
    logic [CW-1:0]        a_cx_reg, a_cy_reg;
    logic [LB-1:0]        a_len_reg;
    logic signed [DB-1:0] a_dx_reg, a_dy_reg;
    logic                 tiny;

    assign tiny = (seg_in.dir_x >= -sefc_pkg::SMALL_DIR) && (seg_in.dir_x <= sefc_pkg::SMALL_DIR)
               && (seg_in.dir_y >= -sefc_pkg::SMALL_DIR) && (seg_in.dir_y <= sefc_pkg::SMALL_DIR);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            a_valid_reg <= 1'b0;
        else if (adv)
            a_valid_reg <= seg_in.valid;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            a_cx_reg  <= seg_in.center_x;
            a_cy_reg  <= seg_in.center_y;
            a_len_reg <= seg_in.seg_length;
            a_dx_reg  <= tiny ? sefc_pkg::UNIT_Q14 : seg_in.dir_x;
            a_dy_reg  <= tiny ? sefc_pkg::UNIT_Q14 : seg_in.dir_y;
        end
    end

    // ---------------- stage B: squares and magnitudes ----------------
    logic                 b_valid_reg;
    logic [CW-1:0]        b_cx_reg, b_cy_reg;
    logic [LB-1:0]        b_len_reg;
    logic [SB-2:0]        b_sqx_reg, b_sqy_reg;
    logic [DB-1:0]        b_ax_reg, b_ay_reg;
    logic                 b_sx_reg, b_sy_reg;
    logic signed [SB-1:0] px, py;

    assign px = SB'(a_dx_reg) * SB'(a_dx_reg);
    assign py = SB'(a_dy_reg) * SB'(a_dy_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            b_valid_reg <= 1'b0;
        else if (adv)
            b_valid_reg <= a_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            b_cx_reg  <= a_cx_reg;
            b_cy_reg  <= a_cy_reg;
            b_len_reg <= a_len_reg;
            b_sqx_reg <= px[SB-2:0];
            b_sqy_reg <= py[SB-2:0];
            b_ax_reg  <= a_dx_reg[DB-1] ? DB'(-a_dx_reg) : DB'(a_dx_reg);
            b_ay_reg  <= a_dy_reg[DB-1] ? DB'(-a_dy_reg) : DB'(a_dy_reg);
            b_sx_reg  <= a_dx_reg[DB-1];
            b_sy_reg  <= a_dy_reg[DB-1];
        end
    end

    // ---------------- square root: sum, then one bit pair a stage ----------------
    logic          s_valid_reg [0:NS];
    logic [CW-1:0] s_cx_reg    [0:NS];
    logic [CW-1:0] s_cy_reg    [0:NS];
    logic [LB-1:0] s_len_reg   [0:NS];
    logic [DB-1:0] s_ax_reg    [0:NS];
    logic [DB-1:0] s_ay_reg    [0:NS];
    logic          s_sx_reg    [0:NS];
    logic          s_sy_reg    [0:NS];
    logic [SB-1:0] s_rem_reg   [0:NS];
    logic [SB-1:0] s_res_reg   [0:NS];
    logic [SB-1:0] s_rem_next  [1:NS];
    logic [SB-1:0] s_res_next  [1:NS];

    always_comb
    begin
        for (int k = 0; k < NS; k++)
        begin
            logic [SB-1:0] bitv;
            logic [SB-1:0] t;
            bitv = SB'(1) << (SB - 2 - 2 * k);
            t    = s_res_reg[k] + bitv;
            if (s_rem_reg[k] >= t)
            begin
                s_rem_next[k+1] = s_rem_reg[k] - t;
                s_res_next[k+1] = (s_res_reg[k] >> 1) + bitv;
            end
            else
            begin
                s_rem_next[k+1] = s_rem_reg[k];
                s_res_next[k+1] = s_res_reg[k] >> 1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k <= NS; k++)
                s_valid_reg[k] <= 1'b0;
        end
        else if (adv)
        begin
            s_valid_reg[0] <= b_valid_reg;
            for (int k = 1; k <= NS; k++)
                s_valid_reg[k] <= s_valid_reg[k-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s_cx_reg[0]  <= b_cx_reg;
            s_cy_reg[0]  <= b_cy_reg;
            s_len_reg[0] <= b_len_reg;
            s_ax_reg[0]  <= b_ax_reg;
            s_ay_reg[0]  <= b_ay_reg;
            s_sx_reg[0]  <= b_sx_reg;
            s_sy_reg[0]  <= b_sy_reg;
            s_rem_reg[0] <= SB'(b_sqx_reg) + SB'(b_sqy_reg);
            s_res_reg[0] <= '0;
            for (int k = 1; k <= NS; k++)
            begin
                s_cx_reg[k]  <= s_cx_reg[k-1];
                s_cy_reg[k]  <= s_cy_reg[k-1];
                s_len_reg[k] <= s_len_reg[k-1];
                s_ax_reg[k]  <= s_ax_reg[k-1];
                s_ay_reg[k]  <= s_ay_reg[k-1];
                s_sx_reg[k]  <= s_sx_reg[k-1];
                s_sy_reg[k]  <= s_sy_reg[k-1];
                s_rem_reg[k] <= s_rem_next[k];
                s_res_reg[k] <= s_res_next[k];
            end
        end
    end

    // ---------------- divide: stage 0 is the multiply, then one quotient bit a stage ----------------
    logic          d_valid_reg [0:NQ];
    logic [CW-1:0] d_cx_reg    [0:NQ];
    logic [CW-1:0] d_cy_reg    [0:NQ];
    logic          d_sx_reg    [0:NQ];
    logic          d_sy_reg    [0:NQ];
    logic [EB-1:0] d_den_reg   [0:NQ];
    logic [NB-1:0] d_nx_reg    [0:NQ];
    logic [NB-1:0] d_ny_reg    [0:NQ];
    logic [NQ-1:0] d_qx_reg    [0:NQ];
    logic [NQ-1:0] d_qy_reg    [0:NQ];
    logic [NB-1:0] d_nx_next   [1:NQ];
    logic [NB-1:0] d_ny_next   [1:NQ];
    logic [NQ-1:0] d_qx_next   [1:NQ];
    logic [NQ-1:0] d_qy_next   [1:NQ];

    always_comb
    begin
        for (int i = 0; i < NQ; i++)
        begin
            logic [NB:0] dsh;
            dsh = (NB+1)'(d_den_reg[i]) << (NQ - 1 - i);
            d_qx_next[i+1] = d_qx_reg[i];
            d_qy_next[i+1] = d_qy_reg[i];
            if ({1'b0, d_nx_reg[i]} >= dsh)
            begin
                d_nx_next[i+1] = NB'({1'b0, d_nx_reg[i]} - dsh);
                d_qx_next[i+1][NQ-1-i] = 1'b1;
            end
            else
                d_nx_next[i+1] = d_nx_reg[i];
            if ({1'b0, d_ny_reg[i]} >= dsh)
            begin
                d_ny_next[i+1] = NB'({1'b0, d_ny_reg[i]} - dsh);
                d_qy_next[i+1][NQ-1-i] = 1'b1;
            end
            else
                d_ny_next[i+1] = d_ny_reg[i];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i <= NQ; i++)
                d_valid_reg[i] <= 1'b0;
        end
        else if (adv)
        begin
            d_valid_reg[0] <= s_valid_reg[NS];
            for (int i = 1; i <= NQ; i++)
                d_valid_reg[i] <= d_valid_reg[i-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            d_cx_reg[0]  <= s_cx_reg[NS];
            d_cy_reg[0]  <= s_cy_reg[NS];
            d_sx_reg[0]  <= s_sx_reg[NS];
            d_sy_reg[0]  <= s_sy_reg[NS];
            d_den_reg[0] <= {s_res_reg[NS][RB-1:0], 1'b0};
            d_nx_reg[0]  <= NB'(s_ax_reg[NS]) * NB'(s_len_reg[NS]);
            d_ny_reg[0]  <= NB'(s_ay_reg[NS]) * NB'(s_len_reg[NS]);
            d_qx_reg[0]  <= '0;
            d_qy_reg[0]  <= '0;
            for (int i = 1; i <= NQ; i++)
            begin
                d_cx_reg[i]  <= d_cx_reg[i-1];
                d_cy_reg[i]  <= d_cy_reg[i-1];
                d_sx_reg[i]  <= d_sx_reg[i-1];
                d_sy_reg[i]  <= d_sy_reg[i-1];
                d_den_reg[i] <= d_den_reg[i-1];
                d_nx_reg[i]  <= d_nx_next[i];
                d_ny_reg[i]  <= d_ny_next[i];
                d_qx_reg[i]  <= d_qx_next[i];
                d_qy_reg[i]  <= d_qy_next[i];
            end
        end
    end

    // ---------------- output: apply offsets and clamp ----------------
    logic [CW-1:0]        end_a_x_reg, end_a_y_reg, end_b_x_reg, end_b_y_reg;
    logic signed [VW-1:0] cxv, cyv, oxv, oyv, hix, hiy;

    assign cxv = $signed(VW'(d_cx_reg[NQ]));
    assign cyv = $signed(VW'(d_cy_reg[NQ]));
    assign oxv = d_sx_reg[NQ] ? -$signed(VW'(d_qx_reg[NQ])) : $signed(VW'(d_qx_reg[NQ]));
    assign oyv = d_sy_reg[NQ] ? -$signed(VW'(d_qy_reg[NQ])) : $signed(VW'(d_qy_reg[NQ]));
    assign hix = upper_bound(width_reg);
    assign hiy = upper_bound(height_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (adv)
            out_valid_reg <= d_valid_reg[NQ];
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            end_a_x_reg <= clamp(cxv + oxv, hix);
            end_a_y_reg <= clamp(cyv + oyv, hiy);
            end_b_x_reg <= clamp(cxv - oxv, hix);
            end_b_y_reg <= clamp(cyv - oyv, hiy);
        end
    end

    assign seg_out.valid   = out_valid_reg;
    assign seg_out.end_a_x = end_a_x_reg;
    assign seg_out.end_a_y = end_a_y_reg;
    assign seg_out.end_b_x = end_b_x_reg;
    assign seg_out.end_b_y = end_b_y_reg;

endmodule
`default_nettype wire

### rtl/sefc_checker.sv
`default_nettype none
`include "assert_macros.svh"
module sefc_checker #(
    parameter int CW = 12
) (
    input wire logic                               clk,
    input wire logic                               rst_n,
    input wire logic                               in_ready,
    input wire logic                               out_valid,
    input wire logic                               out_ready,
    input wire logic [CW-1:0]                      end_a_x,
    input wire logic [CW-1:0]                      end_b_x,
    input wire logic                               psel,
    input wire logic                               penable,
    input wire logic                               pwrite,
    input wire logic [sefc_pkg::ADDR_BITS-1:0]     paddr,
    input wire logic [31:0]                        pwdata,
    input wire logic [31:0]                        prdata
);

    logic stalled;
    logic wr_width;

    assign stalled  = out_valid && !out_ready;
    assign wr_width = psel && penable && pwrite && (paddr == sefc_pkg::REG_IMAGE_WIDTH);

    // Hold a stalled result.
    `ASSERT_NXT(a_out_hold, clk, rst_n, stalled, out_valid)
    `ASSERT_NXT(a_out_stable, clk, rst_n, stalled, $stable(end_a_x) && $stable(end_b_x))
    // Take input whenever the output register is free or draining.
    `ASSERT_IMP(a_in_ready, clk, rst_n, !out_valid || out_ready, in_ready)
    // Read back a width just written.
    `ASSERT_NXT(a_width_rb, clk, rst_n, wr_width,
        (paddr != sefc_pkg::REG_IMAGE_WIDTH) || (prdata[12:0] == $past(pwdata[12:0])))

endmodule

bind segment_endpoints_from_center sefc_checker #(.CW(COORD_BITS)) u_sefc_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ready  (seg_in.ready),
    .out_valid (seg_out.valid),
    .out_ready (seg_out.ready),
    .end_a_x   (seg_out.end_a_x),
    .end_b_x   (seg_out.end_b_x),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata)
);
`default_nettype wire

### tb/sv/tb_segment_endpoints_from_center.sv
`timescale 1ns / 1ps
`default_nettype none
module tb_segment_endpoints_from_center;

    localparam int CW      = 12;
    localparam int LATENCY = 32;

    // One expected pair of endpoints, as the block should return it.
    typedef struct packed {
        logic [CW-1:0] ax;
        logic [CW-1:0] ay;
        logic [CW-1:0] bx;
        logic [CW-1:0] by;
    } endpoints_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic psel = 1'b0;
    logic penable = 1'b0;
    logic pwrite = 1'b0;
    logic [sefc_pkg::ADDR_BITS-1:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic pready;

    int errors = 0;
    int idle_pct = 0;
    int stall_pct = 0;

    always #5 clk = ~clk;

    sefc_in_if  #(.CW(CW)) seg_in ();
    sefc_out_if #(.CW(CW)) seg_out ();

    segment_endpoints_from_center #(.COORD_BITS(CW)) dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .seg_in  (seg_in.sink),
        .seg_out (seg_out.source),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // Print one mismatch line and count it.
    task automatic report_mismatch(input string what, input int got, input int want);
        errors++;
        $display("%0t mismatch %s: got %0d expected %0d", $realtime, what, got, want);
    endtask

    // Endpoint predictor with its own copy of the image size; holds the queue of
    // endpoints still owed by the block.
    class endpoint_board;
        int unsigned img_w = sefc_pkg::WIDTH_RESET;
        int unsigned img_h = sefc_pkg::HEIGHT_RESET;
        endpoints_t pending[$];

        static function longint unsigned isqrt(longint unsigned v);
            longint unsigned r = 0;
            longint unsigned b = 64'd1 << 62;
            while (b > v) b >>= 2;
            while (b != 0)
            begin
                if (v >= r + b)
                begin
                    v -= r + b;
                    r = (r >> 1) + b;
                end
                else
                    r >>= 1;
                b >>= 2;
            end
            return r;
        endfunction

        static function longint scale_dir(longint d, longint len, longint den);
            longint q;
            q = ((d < 0 ? -d : d) * len) / den;
            return d < 0 ? -q : q;
        endfunction

        static function logic [CW-1:0] clamp(longint v, int unsigned size);
            longint hi;
            hi = longint'(size) - 1;
            if (hi > (1 << CW) - 1) hi = (1 << CW) - 1;
            if (v > hi) v = hi;
            if (v < 0) v = 0;
            return v[CW-1:0];
        endfunction

        function void note_segment(logic [CW-1:0] cx, logic [CW-1:0] cy,
                                   logic [sefc_pkg::LEN_BITS-1:0] len,
                                   logic signed [sefc_pkg::DIR_BITS-1:0] dxi,
                                   logic signed [sefc_pkg::DIR_BITS-1:0] dyi);
            longint dx, dy, den, ox, oy;
            endpoints_t e;
            dx = dxi;
            dy = dyi;
            // Treat a near-zero direction as the diagonal.
            if (dx >= -163 && dx <= 163 && dy >= -163 && dy <= 163)
            begin
                dx = 16384;
                dy = 16384;
            end
            den = 2 * longint'(isqrt(longint'(dx * dx + dy * dy)));
            ox = scale_dir(dx, len, den);
            oy = scale_dir(dy, len, den);
            e.ax = clamp(longint'(cx) + ox, img_w);
            e.ay = clamp(longint'(cy) + oy, img_h);
            e.bx = clamp(longint'(cx) - ox, img_w);
            e.by = clamp(longint'(cy) - oy, img_h);
            pending.push_back(e);
        endfunction

        task check_endpoints(endpoints_t got);
            endpoints_t want;
            if (pending.size() == 0)
            begin
                report_mismatch("unexpected item", 0, 0);
                return;
            end
            want = pending.pop_front();
            if (got.ax != want.ax) report_mismatch("end_a_x", got.ax, want.ax);
            if (got.ay != want.ay) report_mismatch("end_a_y", got.ay, want.ay);
            if (got.bx != want.bx) report_mismatch("end_b_x", got.bx, want.bx);
            if (got.by != want.by) report_mismatch("end_b_y", got.by, want.by);
        endtask
    endclass

    endpoint_board board = new();

    // Receiver: stall at random at the falling edge, check at the rising edge.
    always @(negedge clk)
        seg_out.ready <= rst_n && ($urandom_range(99) >= stall_pct);

    always @(posedge clk)
        if (rst_n && seg_out.valid && seg_out.ready)
            board.check_endpoints({seg_out.end_a_x, seg_out.end_a_y,
                                   seg_out.end_b_x, seg_out.end_b_y});

    // Write one register through a setup phase and an access phase.
    task automatic write_reg(input sefc_pkg::reg_addr_t addr, input int unsigned value);
        @(negedge clk);
        psel <= 1'b1;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= value;
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        if (addr == sefc_pkg::REG_IMAGE_WIDTH) board.img_w = value & 13'h1FFF;
        else board.img_h = value & 13'h1FFF;
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    // Offer one segment, idling first at random; return once it is accepted.
    task automatic send_segment(input logic [CW-1:0] cx, input logic [CW-1:0] cy,
                                input logic [sefc_pkg::LEN_BITS-1:0] len,
                                input logic [sefc_pkg::DIR_BITS-1:0] dx,
                                input logic [sefc_pkg::DIR_BITS-1:0] dy);
        while ($urandom_range(99) < idle_pct)
        begin
            seg_in.valid <= 1'b0;
            @(negedge clk);
        end
        seg_in.valid <= 1'b1;
        seg_in.center_x <= cx;
        seg_in.center_y <= cy;
        seg_in.seg_length <= len;
        seg_in.dir_x <= dx;
        seg_in.dir_y <= dy;
        do @(posedge clk); while (!seg_in.ready);
        board.note_segment(cx, cy, len, dx, dy);
        @(negedge clk);
    endtask

    // Drop valid and wait until every owed item is back, then wait for the pipeline to empty.
    task automatic drain;
        seg_in.valid <= 1'b0;
        while (board.pending.size() != 0) @(negedge clk);
        repeat (LATENCY + 4) @(negedge clk);
    endtask

    // Direction component: mostly unit range, some near zero, some any pattern.
    function automatic logic [sefc_pkg::DIR_BITS-1:0] pick_dir();
        int unsigned k;
        k = $urandom_range(9);
        if (k < 6) return sefc_pkg::DIR_BITS'($urandom_range(32768) - 16384);
        if (k < 8) return sefc_pkg::DIR_BITS'($urandom_range(400) - 200);
        return sefc_pkg::DIR_BITS'($urandom);
    endfunction

    task automatic random_segments(input int n);
        logic [CW-1:0] cx, cy;
        for (int i = 0; i < n; i++)
        begin
            // Centres mostly inside the image so that both clamps get exercised.
            cx = ($urandom_range(3) == 0) ? CW'($urandom) : CW'($urandom_range(board.img_w + 8));
            cy = ($urandom_range(3) == 0) ? CW'($urandom) : CW'($urandom_range(board.img_h + 8));
            send_segment(cx, cy, sefc_pkg::LEN_BITS'($urandom), pick_dir(), pick_dir());
        end
    endtask

    initial
    begin
        seg_in.valid = 1'b0;
        seg_in.center_x = '0;
        seg_in.center_y = '0;
        seg_in.seg_length = '0;
        seg_in.dir_x = '0;
        seg_in.dir_y = '0;
        repeat (2) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed: extremes of fields, tiny directions, out-of-range patterns.
        send_segment(0, 0, 0, 0, 0);
        send_segment(12'hFFF, 12'hFFF, 12'hFFF, 16'sd16384, 16'sd0);
        send_segment(320, 240, 12'hFFF, -16'sd16384, 16'sd0);
        send_segment(320, 240, 100, 16'sd163, -16'sd163);
        send_segment(320, 240, 100, 16'sd164, 16'sd0);
        send_segment(320, 240, 100, -16'sd163, 16'sd164);
        send_segment(100, 100, 4095, 16'h7FFF, 16'h8000);
        send_segment(100, 100, 4095, 16'h8000, 16'h8000);
        send_segment(639, 479, 4095, 16'hFFFF, 16'h0001);
        send_segment(0, 479, 2000, -16'sd11585, 16'sd11585);
        send_segment(12'hAAA, 12'h555, 12'h555, 16'h5555, 16'hAAAA);
        send_segment(12'h555, 12'hAAA, 12'hAAA, 16'hAAAA, 16'h5555);
        // Hold off until every result is back.
        drain();

        // Image size extremes: zero, one, full, beyond the coordinate range.
        write_reg(sefc_pkg::REG_IMAGE_WIDTH, 0);
        write_reg(sefc_pkg::REG_IMAGE_HEIGHT, 0);
        send_segment(10, 10, 50, 16'sd16384, 16'sd16384);
        drain();
        write_reg(sefc_pkg::REG_IMAGE_WIDTH, 1);
        write_reg(sefc_pkg::REG_IMAGE_HEIGHT, 8191);
        send_segment(0, 4095, 4095, 16'sd0, 16'sd16384);
        send_segment(1, 2000, 4095, 16'sd16384, -16'sd16384);
        drain();

        // Random phases across sizes and idling mixes.
        for (int ph = 0; ph < 8; ph++)
        begin
            case (ph % 4)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 61; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 61; end
                default: begin idle_pct = 30; stall_pct = 30; end
            endcase
            case (ph)
                0:
                begin
                    write_reg(sefc_pkg::REG_IMAGE_WIDTH, 640);
                    write_reg(sefc_pkg::REG_IMAGE_HEIGHT, 480);
                end
                1:
                begin
                    write_reg(sefc_pkg::REG_IMAGE_WIDTH, 4096);
                    write_reg(sefc_pkg::REG_IMAGE_HEIGHT, 4096);
                end
                2:
                begin
                    write_reg(sefc_pkg::REG_IMAGE_WIDTH, 1);
                    write_reg(sefc_pkg::REG_IMAGE_HEIGHT, 1);
                end
                3:
                begin
                    write_reg(sefc_pkg::REG_IMAGE_WIDTH, 8191);
                    write_reg(sefc_pkg::REG_IMAGE_HEIGHT, 4097);
                end
                default:
                begin
                    write_reg(sefc_pkg::REG_IMAGE_WIDTH, $urandom_range(8191));
                    write_reg(sefc_pkg::REG_IMAGE_HEIGHT, $urandom_range(8191));
                end
            endcase
            random_segments(235);
            drain();
        end

        if (errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    initial
    begin
        #5ms;
        $display("TEST FAILED");
        $finish;
    end
endmodule
`default_nettype wire
